FILE: rtl/sch_pkg.sv
// Shared types, constants and the FNV-1a 64 step for the container header checker.
// No dependencies; every other file imports this package.
package sch_pkg;

    localparam int CNT_BITS_DEF = 34;
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int STATUS_W     = 4;
    localparam int WORD_W       = 64;

    // Header layout, in byte positions
    localparam int HDR_BYTES     = 40;
    localparam int HDR_HASHED    = 32;
    localparam int MAGIC_BYTES   = 8;
    localparam int POS_VER_END   = 11;
    localparam int POS_ORDER_END = 15;
    localparam int POS_LEN_END   = 23;
    localparam int POS_PHASH_END = 31;

    localparam logic [WORD_W-1:0] FNV_BASIS  = 64'hcbf2_9ce4_8422_2325;
    localparam logic [31:0]       ORDER_MARK = 32'h0102_0304;
    // Expected magic, byte 0 in the low bits
    localparam logic [WORD_W-1:0] MAGIC_WORD = 64'h4554_4154_5346_5041;

    localparam logic [CFG_W-1:0] VERSION_RST = 32'd1;
    localparam logic [CFG_W-1:0] MAX_PAY_RST = 32'd67108864;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_VERSION = 2'd0,
        CFG_MAX_PAYLOAD      = 2'd1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 4'd0,
        ST_TRUNCATED    = 4'd1,
        ST_MAGIC        = 4'd2,
        ST_VERSION      = 4'd3,
        ST_BYTE_ORDER   = 4'd4,
        ST_LEN_UNUSABLE = 4'd5,
        ST_SIZE         = 4'd6,
        ST_HDR_HASH     = 4'd7,
        ST_PAYLOAD_HASH = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_item;

    // Everything the final check needs, frozen at the last byte
    typedef struct packed {
        logic              magic_ok;
        logic [31:0]       version;
        logic [31:0]       marker;
        logic [WORD_W-1:0] length;
        logic [WORD_W-1:0] pay_hash_seen;
        logic [WORD_W-1:0] hdr_hash_seen;
        logic [WORD_W-1:0] hdr_hash_run;
        logic [WORD_W-1:0] pay_hash_run;
        logic [WORD_W-1:0] size;
    } t_snap;

    // One FNV-1a step; the prime 2^40 + 0x1b3 is applied as shifts and adds
    function automatic logic [WORD_W-1:0] fnv_step(input logic [WORD_W-1:0] h,
                                                   input logic [7:0] b);
        logic [WORD_W-1:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        return MAGIC_WORD[{idx, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/sch_scan.sv
// Byte scan stage: running hashes, header field capture, byte counter and snapshot register.
// Depends on sch_pkg.
module sch_scan import sch_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    input  t_item i_item,
    output logic  o_take,
    input  logic  i_snap_ready,
    output logic  o_snap_valid,
    output t_snap o_snap
);

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_magic_ok, n_magic_ok;
    logic [WORD_W-1:0]     r_hdr_field, n_hdr_field;
    logic [31:0]           r_version, n_version;
    logic [31:0]           r_marker, n_marker;
    logic [WORD_W-1:0]     r_length, n_length;
    logic [WORD_W-1:0]     r_phash_seen, n_phash_seen;
    logic [WORD_W-1:0]     r_hdr_run, n_hdr_run;
    logic [WORD_W-1:0]     r_pay_run, n_pay_run;
    logic                  r_snap_valid;
    t_snap                 r_snap;
    logic                  in_hdr;

    assign o_take = i_item_valid && (!i_item.last || i_snap_ready);
    assign in_hdr = r_count < COUNT_BITS'(HDR_BYTES);

    always_comb begin
        n_magic_ok   = r_magic_ok;
        n_hdr_field  = r_hdr_field;
        n_version    = r_version;
        n_marker     = r_marker;
        n_length     = r_length;
        n_phash_seen = r_phash_seen;
        n_hdr_run    = r_hdr_run;
        n_pay_run    = r_pay_run;
        if (r_count < COUNT_BITS'(MAGIC_BYTES) && i_item.data != magic_byte(r_count[2:0])) begin
            n_magic_ok = 1'b0;
        end
        if (r_count < COUNT_BITS'(HDR_HASHED)) begin
            n_hdr_run = fnv_step(r_hdr_run, i_item.data);
        end
        if (in_hdr) begin
            n_hdr_field = {i_item.data, r_hdr_field[WORD_W-1:8]};
            if (r_count == COUNT_BITS'(POS_VER_END)) begin
                n_version = n_hdr_field[63:32];
            end
            if (r_count == COUNT_BITS'(POS_ORDER_END)) begin
                n_marker = n_hdr_field[63:32];
            end
            if (r_count == COUNT_BITS'(POS_LEN_END)) begin
                n_length = n_hdr_field;
            end
            if (r_count == COUNT_BITS'(POS_PHASH_END)) begin
                n_phash_seen = n_hdr_field;
            end
        end else begin
            n_pay_run = fnv_step(r_pay_run, i_item.data);
        end
        // Saturate at all ones
        n_count = (r_count != '1) ? r_count + COUNT_BITS'(1) : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_magic_ok   <= 1'b1;
            r_hdr_field  <= '0;
            r_version    <= '0;
            r_marker     <= '0;
            r_length     <= '0;
            r_phash_seen <= '0;
            r_hdr_run    <= FNV_BASIS;
            r_pay_run    <= FNV_BASIS;
            r_snap_valid <= 1'b0;
        end else begin
            if (o_take && i_item.last) begin
                // Freeze the finished file, start the next one from scratch
                r_snap_valid         <= 1'b1;
                r_snap.magic_ok      <= n_magic_ok;
                r_snap.version       <= n_version;
                r_snap.marker        <= n_marker;
                r_snap.length        <= n_length;
                r_snap.pay_hash_seen <= n_phash_seen;
                r_snap.hdr_hash_seen <= n_hdr_field;
                r_snap.hdr_hash_run  <= n_hdr_run;
                r_snap.pay_hash_run  <= n_pay_run;
                r_snap.size          <= WORD_W'(n_count);
                r_count              <= '0;
                r_magic_ok           <= 1'b1;
                r_hdr_field          <= '0;
                r_version            <= '0;
                r_marker             <= '0;
                r_length             <= '0;
                r_phash_seen         <= '0;
                r_hdr_run            <= FNV_BASIS;
                r_pay_run            <= FNV_BASIS;
            end else begin
                if (i_snap_ready) begin
                    r_snap_valid <= 1'b0;
                end
                if (o_take) begin
                    r_count      <= n_count;
                    r_magic_ok   <= n_magic_ok;
                    r_hdr_field  <= n_hdr_field;
                    r_version    <= n_version;
                    r_marker     <= n_marker;
                    r_length     <= n_length;
                    r_phash_seen <= n_phash_seen;
                    r_hdr_run    <= n_hdr_run;
                    r_pay_run    <= n_pay_run;
                end
            end
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

FILE: rtl/sch_judge.sv
// Final check stage: ordered status decision and the result register.
// Depends on sch_pkg.
module sch_judge import sch_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_snap_valid,
    input  t_snap               i_snap,
    output logic                o_snap_ready,
    input  logic [CFG_W-1:0]    i_expected_version,
    input  logic [CFG_W-1:0]    i_max_payload_bytes,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_check_status,
    output logic [WORD_W-1:0]   o_declared_length
);

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_length;
    t_status             n_status;
    logic [WORD_W-1:0]   n_length;
    logic [WORD_W-1:0]   body_size;
    logic                out_ready;

    assign out_ready    = !r_out_valid || !i_out_stall;
    assign o_snap_ready = !i_snap_valid || out_ready;
    assign body_size    = i_snap.size - WORD_W'(HDR_BYTES);

    // First failing check wins
    always_comb begin
        n_length = i_snap.length;
        if (i_snap.size < WORD_W'(HDR_BYTES)) begin
            n_status = ST_TRUNCATED;
            n_length = '0;
        end else if (!i_snap.magic_ok) begin
            n_status = ST_MAGIC;
        end else if (i_snap.version != i_expected_version) begin
            n_status = ST_VERSION;
        end else if (i_snap.marker != ORDER_MARK) begin
            n_status = ST_BYTE_ORDER;
        end else if (i_snap.length > WORD_W'(i_max_payload_bytes) ||
                     i_snap.length > body_size) begin
            n_status = ST_LEN_UNUSABLE;
        end else if (body_size != i_snap.length) begin
            n_status = ST_SIZE;
        end else if (i_snap.hdr_hash_seen != i_snap.hdr_hash_run) begin
            n_status = ST_HDR_HASH;
        end else if (i_snap.pay_hash_seen != i_snap.pay_hash_run) begin
            n_status = ST_PAYLOAD_HASH;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_snap_valid && out_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid && out_ready) begin
            r_status <= n_status;
            r_length <= n_length;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_check_status    = r_status;
    assign o_declared_length = r_length;

endmodule

FILE: rtl/state_container_header_checker_core.sv
// Top level of the saved-state container header checker: input register, configuration
// registers, scan stage and check stage. Depends on sch_pkg, sch_scan and sch_judge.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one byte of the container file per
//   transfer, with i_last_byte set on the final byte. Each file yields exactly one
//   result on the output channel (o_out_valid / i_out_stall): o_check_status and
//   o_declared_length. Non-final bytes produce no result.
//   Throughput is one byte per cycle while o_in_stall is low; the FNV-1a step on the running hash register
//   (one pass through the constant-prime shift-add) sets that figure.
//   A final byte passes the input register, then the scan stage with its snapshot register,
//   then the check stage with its result register, before its result shows.
//   Configuration is a plain write port; write it only while no file is in flight.
//   Reset returns the configuration to its defaults (version 1, 64 MiB payload limit),
//   clears all scan state and empties every stage.
//   When the receiver stalls, the result register holds; a second finished file waits
//   in the snapshot register, and ordinary bytes keep streaming. Only a further final
//   byte that finds both slots full raises o_in_stall.
module state_container_header_checker_core import sch_pkg::*; #(
    parameter int COUNT_BITS = CNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STATUS_W-1:0]  o_check_status,
    output logic [WORD_W-1:0]    o_declared_length
);

    logic             r_in_valid;
    t_item            r_in_item;
    logic [CFG_W-1:0] r_exp_version;
    logic [CFG_W-1:0] r_max_payload;
    logic             scan_take;
    logic             snap_valid;
    logic             snap_ready;
    t_snap            snap;
    logic             in_xfer;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= VERSION_RST;
            r_max_payload <= MAX_PAY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_VERSION: r_exp_version <= i_cfg_data;
                CFG_MAX_PAYLOAD:      r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: refill in the same cycle the scan stage drains it
    assign o_in_stall = r_in_valid && !scan_take;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (scan_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item.data <= i_data_byte;
            r_in_item.last <= i_last_byte;
        end
    end

    sch_scan #(
        .COUNT_BITS(COUNT_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(r_in_valid),
        .i_item      (r_in_item),
        .o_take      (scan_take),
        .i_snap_ready(snap_ready),
        .o_snap_valid(snap_valid),
        .o_snap      (snap)
    );

    sch_judge u_judge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_snap_valid       (snap_valid),
        .i_snap             (snap),
        .o_snap_ready       (snap_ready),
        .i_expected_version (r_exp_version),
        .i_max_payload_bytes(r_max_payload),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_check_status     (o_check_status),
        .o_declared_length  (o_declared_length)
    );

endmodule

FILE: rtl/sch_chk.sv
// Port-level checker for the container header checker, bound to the top level.
// Depends on sch_pkg and state_container_header_checker_core.
module sch_chk import sch_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [7:0]           i_data_byte,
    input logic                 i_last_byte,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [STATUS_W-1:0]  o_check_status,
    input logic [WORD_W-1:0]    o_declared_length
);

    // A stalled input byte holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_data_byte) &&
        $stable(i_last_byte))
        else $error("stalled input byte changed");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_check_status) &&
        $stable(o_declared_length))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_check_status <= STATUS_W'(ST_PAYLOAD_HASH))
        else $error("status code out of range");

    a_trunc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_check_status == STATUS_W'(ST_TRUNCATED) |->
        o_declared_length == '0)
        else $error("truncated file reports a length");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind state_container_header_checker_core sch_chk u_sch_chk (.*);
